@@ hdl/rmm_pkg.sv @@
// Shared widths and types for the running min/max/mean statistics block.
// Used by rmm_mul, rmm_div and running_min_max_mean; depends on nothing.
package rmm_pkg;

   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   // signed width of mean*count + value, formed exactly
   localparam int NUM_BITS = VALUE_BITS + COUNT_BITS + 1;
   localparam int MUL_STEP_BITS = $clog2(COUNT_BITS);
   localparam int DIV_STEP_BITS = $clog2(VALUE_BITS);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [COUNT_BITS:0] divisor_type;
   typedef logic signed [NUM_BITS-1:0] num_type;

endpackage

@@ hdl/running_min_max_mean.sv @@
// Running minimum, maximum and truncated mean over a stream of nullable Q16.16 values.
// Depends on rmm_pkg, rmm_mul and rmm_div.
//
//   port group   direction   contents
//   req_*        in          sample_value (signed 32), sample_present
//   rsp_*        out         running_minimum/maximum/mean, present_count, stats_known
//
// An absent sample, or the first present one, goes straight to FINISH to have its result registered.
// Any later present sample passes through MULTIPLY and then DIVIDE first: the
// serial multiplier walks the count bits, then the divider produces one quotient bit a cycle.
// One request is in work at a time; the next is taken the cycle after the result is registered,
// even while that result waits on rsp_ready. The result is held back while an older one waits.
// Synchronous reset clears all statistics to zero and empties the result register.
module running_min_max_mean (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rmm_pkg::value_type req_sample_value,
   input  logic               req_sample_present,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rmm_pkg::value_type rsp_running_minimum,
   output rmm_pkg::value_type rsp_running_maximum,
   output rmm_pkg::value_type rsp_running_mean,
   output rmm_pkg::count_type rsp_present_count,
   output logic               rsp_stats_known
);

   typedef enum logic [1:0] {
      IDLE,
      MULTIPLY,
      DIVIDE,
      FINISH
   } state_type;

   state_type            state_ff, state_in;
   rmm_pkg::value_type   min_ff, min_in;
   rmm_pkg::value_type   max_ff, max_in;
   rmm_pkg::value_type   mean_ff, mean_in;
   rmm_pkg::count_type   count_ff, count_in;
   logic                 seen_ff, seen_in;
   rmm_pkg::divisor_type dvsr_ff, dvsr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rmm_pkg::value_type   rsp_min_ff, rsp_min_in;
   rmm_pkg::value_type   rsp_max_ff, rsp_max_in;
   rmm_pkg::value_type   rsp_mean_ff, rsp_mean_in;
   rmm_pkg::count_type   rsp_count_ff, rsp_count_in;
   logic                 rsp_known_ff, rsp_known_in;

   logic                 accept;
   logic                 mul_start;
   logic                 mul_done;
   rmm_pkg::num_type     product;
   logic                 div_done;
   rmm_pkg::value_type   quotient;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;
   assign mul_start = accept && req_sample_present && seen_ff;

   rmm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mean    (mean_ff),
      .count   (count_ff),
      .value   (req_sample_value),
      .done    (mul_done),
      .product (product)
   );

   rmm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_done),
      .numerator (product),
      .divisor   (dvsr_ff),
      .done      (div_done),
      .quotient  (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      mean_in      = mean_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      dvsr_in      = dvsr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_count_in = rsp_count_ff;
      rsp_known_in = rsp_known_ff;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               state_in = FINISH;
               if (req_sample_present) begin
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
                  if (!seen_ff) begin
                     min_in  = req_sample_value;
                     max_in  = req_sample_value;
                     mean_in = req_sample_value;
                     seen_in = 1'b1;
                  end else begin
                     if (req_sample_value < min_ff) begin
                        min_in = req_sample_value;
                     end
                     if (req_sample_value > max_ff) begin
                        max_in = req_sample_value;
                     end
                     // weight of the old mean is the count before this request
                     dvsr_in  = {1'b0, count_ff} + 1'b1;
                     state_in = MULTIPLY;
                  end
               end
            end
         end
         MULTIPLY: begin
            if (mul_done) begin
               state_in = DIVIDE;
            end
         end
         DIVIDE: begin
            if (div_done) begin
               mean_in  = quotient;
               state_in = FINISH;
            end
         end
         FINISH: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = min_ff;
               rsp_max_in   = max_ff;
               rsp_mean_in  = mean_ff;
               rsp_count_in = count_ff;
               rsp_known_in = seen_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         min_ff       <= '0;
         max_ff       <= '0;
         mean_ff      <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         mean_ff      <= mean_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvsr_ff      <= dvsr_in;
      rsp_min_ff   <= rsp_min_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_count_ff <= rsp_count_in;
      rsp_known_ff <= rsp_known_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_running_minimum = rsp_min_ff;
   assign rsp_running_maximum = rsp_max_ff;
   assign rsp_running_mean    = rsp_mean_ff;
   assign rsp_present_count   = rsp_count_ff;
   assign rsp_stats_known     = rsp_known_ff;

endmodule

@@ hdl/rmm_mul.sv @@
// Bit-serial shift-add multiplier: forms mean * count + value, one count bit a cycle.
// Depends on rmm_pkg.
module rmm_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  rmm_pkg::value_type mean,
   input  rmm_pkg::count_type count,
   input  rmm_pkg::value_type value,
   output logic               done,
   output rmm_pkg::num_type   product
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [rmm_pkg::MUL_STEP_BITS-1:0]   step_ff, step_in;
   rmm_pkg::num_type                    acc_ff, acc_in;
   rmm_pkg::num_type                    mcand_ff, mcand_in;
   rmm_pkg::count_type                  mplier_ff, mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         step_in   = rmm_pkg::MUL_STEP_BITS'(rmm_pkg::COUNT_BITS - 1);
         // seed the accumulator with the new value so the sum comes for free
         acc_in    = {{(rmm_pkg::NUM_BITS - rmm_pkg::VALUE_BITS){value[rmm_pkg::VALUE_BITS-1]}},
                      value};
         mcand_in  = {{(rmm_pkg::NUM_BITS - rmm_pkg::VALUE_BITS){mean[rmm_pkg::VALUE_BITS-1]}},
                      mean};
         mplier_in = count;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         step_in   = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff   <= step_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ hdl/rmm_div.sv @@
// Restoring divider: signed numerator by unsigned divisor, one quotient bit a cycle,
// truncating toward zero. Depends on rmm_pkg.
module rmm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  rmm_pkg::num_type     numerator,
   input  rmm_pkg::divisor_type divisor,
   output logic                 done,
   output rmm_pkg::value_type   quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                neg_ff, neg_in;
   logic [rmm_pkg::DIV_STEP_BITS-1:0]   step_ff, step_in;
   rmm_pkg::divisor_type                rem_ff, rem_in;
   rmm_pkg::divisor_type                dvsr_ff, dvsr_in;
   logic [rmm_pkg::VALUE_BITS-1:0]      low_ff, low_in;
   rmm_pkg::value_type                  quo_ff, quo_in;

   logic [rmm_pkg::NUM_BITS-1:0]        mag;
   logic [rmm_pkg::COUNT_BITS+1:0]      trial;
   logic [rmm_pkg::COUNT_BITS+1:0]      diff;
   logic                                fits;
   logic [rmm_pkg::VALUE_BITS-1:0]      q_next;

   assign mag    = numerator[rmm_pkg::NUM_BITS-1] ? (~numerator + 1'b1) : numerator;
   assign trial  = {rem_ff, low_ff[rmm_pkg::VALUE_BITS-1]};
   assign fits   = trial >= {1'b0, dvsr_ff};
   assign diff   = trial - {1'b0, dvsr_ff};
   assign q_next = {low_ff[rmm_pkg::VALUE_BITS-2:0], fits};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = numerator[rmm_pkg::NUM_BITS-1];
         step_in = rmm_pkg::DIV_STEP_BITS'(rmm_pkg::VALUE_BITS - 1);
         // the quotient fits the value width, so the top bits start below the divisor
         rem_in  = mag[rmm_pkg::NUM_BITS-1:rmm_pkg::VALUE_BITS];
         low_in  = mag[rmm_pkg::VALUE_BITS-1:0];
         dvsr_in = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[rmm_pkg::COUNT_BITS:0] : trial[rmm_pkg::COUNT_BITS:0];
         low_in  = q_next;
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? (~q_next + 1'b1) : q_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for running_min_max_mean: min, max, truncated mean and count.
// Depends on rmm_pkg and the running_min_max_mean RTL; predicts every result internally.
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      rmm_pkg::value_type minimum;
      rmm_pkg::value_type maximum;
      rmm_pkg::value_type mean;
      rmm_pkg::count_type count;
      logic               known;
   } stats_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   rmm_pkg::value_type req_sample_value = '0;
   logic               req_sample_present = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rmm_pkg::value_type rsp_running_minimum;
   rmm_pkg::value_type rsp_running_maximum;
   rmm_pkg::value_type rsp_running_mean;
   rmm_pkg::count_type rsp_present_count;
   logic               rsp_stats_known;

   // predicted statistics after every accepted request
   rmm_pkg::value_type stat_min = '0;
   rmm_pkg::value_type stat_max = '0;
   rmm_pkg::value_type stat_mean = '0;
   rmm_pkg::count_type stat_count = '0;
   logic               stat_known = 1'b0;

   stats_type pending_stats[$];
   int        error_count = 0;
   int        cycle_count = 0;
   int        send_idle_pct = 0;
   int        recv_idle_pct = 0;

   running_min_max_mean DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_value    (req_sample_value),
      .req_sample_present  (req_sample_present),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_running_minimum (rsp_running_minimum),
      .rsp_running_maximum (rsp_running_maximum),
      .rsp_running_mean    (rsp_running_mean),
      .rsp_present_count   (rsp_present_count),
      .rsp_stats_known     (rsp_stats_known)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Fold one accepted request into the statistics and queue the result it causes.
   function automatic void update_stats(input rmm_pkg::value_type v, input logic present);
      longint signed num;
      longint signed den;
      longint signed quo;
      stats_type s;
      if (present) begin
         if (!stat_known) begin
            stat_min = v;
            stat_max = v;
            stat_mean = v;
            stat_known = 1'b1;
         end else begin
            if (v < stat_min) stat_min = v;
            if (v > stat_max) stat_max = v;
            num = longint'(stat_mean) * longint'(stat_count) + longint'(v);
            den = longint'(stat_count) + 64'sd1;
            quo = num / den;
            stat_mean = quo[rmm_pkg::VALUE_BITS-1:0];
         end
         if (stat_count != '1) stat_count = stat_count + 1'b1;
      end
      s.minimum = stat_min;
      s.maximum = stat_max;
      s.mean = stat_mean;
      s.count = stat_count;
      s.known = stat_known;
      pending_stats.insert(pending_stats.size(), s);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] expected,
                                         input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, name, expected, actual);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      stats_type s;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $display("%0t: unexpected result: expected none actual min %h max %h mean %h",
                     $time, rsp_running_minimum, rsp_running_maximum, rsp_running_mean);
            error_count++;
         end else begin
            s = pending_stats.pop_front();
            compare_field("running_minimum", s.minimum, rsp_running_minimum);
            compare_field("running_maximum", s.maximum, rsp_running_maximum);
            compare_field("running_mean", s.mean, rsp_running_mean);
            compare_field("present_count", 32'(s.count), 32'(rsp_present_count));
            compare_field("stats_known", 32'(s.known), 32'(rsp_stats_known));
         end
      end
   end

   // Present one request, holding it until the handshake completes.
   task automatic send_sample(input rmm_pkg::value_type v, input logic present);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 8);
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample_value <= v;
      req_sample_present <= present;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      update_stats(v, present);
   endtask

   // Hold the sender off until every queued result has come back.
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
   endtask

   function automatic rmm_pkg::value_type draw_sample_value();
      rmm_pkg::value_type v;
      case ($urandom_range(9))
         0: v = 32'h7fff_ffff;
         1: v = 32'h8000_0000;
         2, 3: begin
            v = $urandom_range(0, 262143);
            v = v - 32'sd131072;
         end
         4: v = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic test_empty_reports();
      // nothing seen yet: absent requests must report all zeros
      send_sample(32'h7fff_ffff, 1'b0);
      send_sample(32'h8000_0000, 1'b0);
      send_sample(32'h0000_0000, 1'b0);
   endtask

   task automatic test_directed_extremes();
      send_sample(32'h7fff_ffff, 1'b1);   // seed
      send_sample(32'h8000_0000, 1'b1);   // mean of -1/2 truncates to zero
      send_sample(32'h1234_5678, 1'b0);
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'hffff_ffff, 1'b1);
      send_sample(32'h0000_0001, 1'b1);
      repeat (4) send_sample(32'h8000_0000, 1'b1);
      send_sample(32'hedcb_a987, 1'b0);
      repeat (4) send_sample(32'h7fff_ffff, 1'b1);
      send_sample(32'h0001_0000, 1'b1);
      send_sample(32'hffff_0000, 1'b1);
      send_sample(32'h5555_5555, 1'b1);
      send_sample(32'haaaa_aaaa, 1'b1);
      send_sample(32'hffff_ffff, 1'b0);
   endtask

   task automatic test_random_stream(input int send_pct, input int recv_pct, input int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         send_sample(draw_sample_value(), $urandom_range(99) < 85);
         if (i % 120 == 119) wait_for_results();
      end
   endtask

   initial begin
      @(negedge reset);
      send_idle_pct = 24;
      recv_idle_pct = 54;
      test_empty_reports();
      test_directed_extremes();
      wait_for_results();
      test_random_stream(24, 54, 400);
      test_random_stream(54, 24, 400);
      test_random_stream(0, 0, 350);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_stats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
